// ----- rtl/duplicate_sequence_filter_top_defines.svh -----
// Assertion macros used by the checker file of the duplicate sequence filter.
`ifndef DUPLICATE_SEQUENCE_FILTER_TOP_DEFINES_SVH
`define DUPLICATE_SEQUENCE_FILTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dsf_pkg.sv -----
`timescale 1ns / 1ps

package dsf_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int SEQ_WIDTH    = 32;
   localparam int IN_WIDTH     = 32;
   localparam int FILL_WIDTH   = $clog2(WINDOW_DEPTH + 1);

   typedef logic [IN_WIDTH-1:0]     in_seq_type;
   typedef logic [SEQ_WIDTH-1:0]    seq_type;
   typedef logic [FILL_WIDTH-1:0]   fill_type;
   typedef logic [WINDOW_DEPTH-1:0] window_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_UPDATE  = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } cmd_type;

endpackage

// ----- rtl/dsf_req_if.sv -----
`timescale 1ns / 1ps

interface dsf_req_if;
   import dsf_pkg::*;

   logic       valid;
   logic       ready;
   in_seq_type seq_number;

   modport source (output valid, output seq_number, input ready);
   modport sink (input valid, input seq_number, output ready);
endinterface

// ----- rtl/dsf_rsp_if.sv -----
`timescale 1ns / 1ps

interface dsf_rsp_if;
   logic valid;
   logic ready;
   logic is_duplicate;

   modport source (output valid, output is_duplicate, input ready);
   modport sink (input valid, input is_duplicate, output ready);
endinterface

// ----- rtl/dsf_controller.sv -----
`timescale 1ns / 1ps

module dsf_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsf_pkg::cmd_type cmd
);
   import dsf_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   assign cmd.load    = req_ready && req_valid;
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.commit  = commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/dsf_datapath.sv -----
`timescale 1ns / 1ps

module dsf_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dsf_pkg::cmd_type    cmd,
   input  dsf_pkg::in_seq_type req_seq_number,
   output logic                rsp_is_duplicate
);
   import dsf_pkg::*;

   seq_type    seq_ff;
   seq_type    seq_in;
   seq_type    cells_ff [WINDOW_DEPTH];
   seq_type    cells_in [WINDOW_DEPTH];
   seq_type    next_up  [WINDOW_DEPTH];
   fill_type   fill_ff;
   fill_type   fill_in;
   window_type match_ff;
   window_type match_in;
   window_type shift;
   logic       dup_ff;
   logic       dup_in;
   logic       dup;
   logic       full;
   logic       drop;
   fill_type   wpos;

   assign seq_in = cmd.load ? SEQ_WIDTH'(req_seq_number) : seq_ff;

   always_comb begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         match_in[k] = cmd.compare ? ((FILL_WIDTH'(k) < fill_ff) && (cells_ff[k] == seq_ff))
                                   : match_ff[k];
      end
   end

   for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_next
      if (g == WINDOW_DEPTH - 1) begin : g_last
         assign next_up[g] = seq_ff;
      end else begin : g_inner
         assign next_up[g] = cells_ff[g+1];
      end
   end

   assign dup  = |match_ff;
   assign full = (fill_ff == FILL_WIDTH'(WINDOW_DEPTH));
   assign drop = dup || full;
   assign wpos = drop ? fill_ff - FILL_WIDTH'(1) : fill_ff;

   // A cell shifts toward the oldest end when it sits at or above the dropped cell.
   always_comb begin
      window_type ones;
      ones = '1;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         shift[k] = dup ? |(match_ff & ~(ones << (k + 1))) : full;
      end
   end

   always_comb begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         priority if (cmd.commit && (FILL_WIDTH'(k) == wpos)) begin
            cells_in[k] = seq_ff;
         end else if (cmd.commit && shift[k] && (FILL_WIDTH'(k) < wpos)) begin
            cells_in[k] = next_up[k];
         end else begin
            cells_in[k] = cells_ff[k];
         end
      end
   end

   assign fill_in = (cmd.commit && !drop) ? fill_ff + FILL_WIDTH'(1) : fill_ff;
   assign dup_in  = cmd.commit ? dup : dup_ff;

   assign rsp_is_duplicate = dup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      match_ff <= match_in;
      dup_ff   <= dup_in;
      cells_ff <= cells_in;
   end

endmodule

// ----- rtl/duplicate_sequence_filter_top.sv -----
`timescale 1ns / 1ps

// Duplicate sequence filter: each beat on the request channel carries one packet sequence
// number, and each beat on the response channel says whether that number was already held in
// a window of the most recent distinct numbers, which then moves it to the newest place; a new
// number is appended, dropping the oldest when the window is full. The window starts empty
// after reset. Each item passes the idle, compare and update states: the beat is taken in
// the idle state, the compare state registers the compare result of all window cells, and
// the update state updates the window and loads the response register; no new beat is taken
// until then. The response register lets the next request beat be taken while an earlier
// response waits; if it is still held when the next item is ready to finish, the block waits.

module duplicate_sequence_filter_top (
   input logic        clock,
   input logic        reset,
   dsf_req_if.sink    req_if,
   dsf_rsp_if.source  rsp_if
);
   import dsf_pkg::*;

   cmd_type cmd;

   dsf_controller u_dsf_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   dsf_datapath u_dsf_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_seq_number   (req_if.seq_number),
      .rsp_is_duplicate (rsp_if.is_duplicate)
   );

endmodule

// ----- rtl/dsf_checker.sv -----
`timescale 1ns / 1ps
`include "duplicate_sequence_filter_top_defines.svh"

module dsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_duplicate
);

   `DSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_duplicate), "Stalled response beat changed.")

   `DSF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "Request taken again while an item is in work.")

   `DSF_ASSERT_SAME(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 3), "Response beat without a request three cycles earlier.")

endmodule

bind duplicate_sequence_filter_top dsf_checker u_dsf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_is_duplicate (rsp_if.is_duplicate)
);

// ----- dv/duplicate_sequence_filter_top_tb.sv -----
`timescale 1ns / 1ps

module duplicate_sequence_filter_top_tb;
   import dsf_pkg::*;

   logic clock;
   logic reset;

   dsf_req_if req_if ();
   dsf_rsp_if rsp_if ();

   duplicate_sequence_filter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   in_seq_type seq_pending_q[$];
   bit         expected_dup_q[$];
   seq_type    window_cells[WINDOW_DEPTH];
   int         window_count = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   in_seq_type seq_pool[20];
   in_seq_type recent_seq[$];

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Moves a matching number to the newest place, or appends a new one and
   // drops the oldest when the window is full.
   function automatic bit check_and_record(input in_seq_type raw);
      seq_type seq;
      int      hit;
      bit      dup;
      seq = seq_type'(raw);
      hit = -1;
      for (int k = 0; k < window_count; k++) begin
         if (hit < 0 && window_cells[k] == seq) hit = k;
      end
      dup = (hit >= 0);
      if (!dup && window_count == WINDOW_DEPTH) hit = 0;
      if (hit >= 0) begin
         for (int k = hit; k < window_count - 1; k++) window_cells[k] = window_cells[k + 1];
         window_count--;
      end
      window_cells[window_count] = seq;
      window_count++;
      return dup;
   endfunction

   // A stretch of cycles without any idling on either side.
   function automatic bit take_break();
      if (cycle_count >= 2000 && cycle_count < 5000) return 1'b0;
      return $urandom_range(99) < 8;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.seq_number <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (seq_pending_q.size() > 0 && !take_break()) begin
            req_if.valid <= 1'b1;
            req_if.seq_number <= seq_pending_q.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !take_break();
   end

   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_dup_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual is_duplicate=%b",
                        $time, rsp_if.is_duplicate);
               mismatch_count++;
            end else begin
               want = expected_dup_q.pop_front();
               if (rsp_if.is_duplicate !== want) begin
                  $display("%0t: is_duplicate expected %b, actual %b",
                           $time, want, rsp_if.is_duplicate);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            expected_dup_q.insert(expected_dup_q.size(), check_and_record(req_if.seq_number));
      end
   end

   function automatic in_seq_type pick_random_seq(input int index);
      int roll;
      roll = $urandom_range(99);
      if (index % 300 == 0) begin
         foreach (seq_pool[p]) seq_pool[p] = $urandom;
      end
      if (roll < 50) begin
         return seq_pool[$urandom_range(19)];
      end else if (roll < 65 && recent_seq.size() > 0) begin
         return recent_seq[$urandom_range(recent_seq.size() - 1)];
      end else if (roll < 75) begin
         seq_pool[$urandom_range(19)] = $urandom;
         return seq_pool[$urandom_range(19)];
      end
      return $urandom;
   endfunction

   initial begin
      in_seq_type seq;
      reset = 1'b1;

      // Extremes and duplicates in a nearly empty window.
      seq_pending_q.insert(seq_pending_q.size(), 32'h0000_0000);
      seq_pending_q.insert(seq_pending_q.size(), 32'hFFFF_FFFF);
      seq_pending_q.insert(seq_pending_q.size(), 32'h0000_0000);
      seq_pending_q.insert(seq_pending_q.size(), 32'hFFFF_FFFF);
      // Fill the window up to its full depth.
      for (int k = 0; k < 14; k++)
         seq_pending_q.insert(seq_pending_q.size(), in_seq_type'(1) << k);
      // A new number into a full window drops the oldest, which is then new again.
      seq_pending_q.insert(seq_pending_q.size(), 32'hA5A5_5A5A);
      seq_pending_q.insert(seq_pending_q.size(), 32'h0000_0000);
      seq_pending_q.insert(seq_pending_q.size(), 32'h8000_0000);
      // Duplicates in the middle, at the newest and at the oldest place.
      seq_pending_q.insert(seq_pending_q.size(), 32'h0000_0010);
      seq_pending_q.insert(seq_pending_q.size(), 32'h0000_0010);
      seq_pending_q.insert(seq_pending_q.size(), 32'h0000_0002);

      foreach (seq_pool[p]) seq_pool[p] = $urandom;
      for (int i = 0; i < 1900; i++) begin
         seq = pick_random_seq(i);
         seq_pending_q.insert(seq_pending_q.size(), seq);
         recent_seq.insert(recent_seq.size(), seq);
         if (recent_seq.size() > 20) void'(recent_seq.pop_front());
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (seq_pending_q.size() > 0 || req_if.valid || expected_dup_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_dup_q.size() == 0) begin
         $display("duplicate_sequence_filter_top: match");
      end else begin
         $display("duplicate_sequence_filter_top: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("duplicate_sequence_filter_top: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dsf_pkg.sv
rtl/dsf_req_if.sv
rtl/dsf_rsp_if.sv
rtl/dsf_controller.sv
rtl/dsf_datapath.sv
rtl/duplicate_sequence_filter_top.sv
rtl/dsf_checker.sv
dv/duplicate_sequence_filter_top_tb.sv
